// ===== design/dcf77_pkg.sv =====
`timescale 1ns / 1ps

package dcf77_pkg;

	// input beat: one measured second
	typedef struct packed {
		logic [7:0] on_ticks;
		logic [7:0] off_ticks;
	} dcf_in_t;

	// result beat: displayed time and status
	typedef struct packed {
		logic [4:0] shown_hour;
		logic [5:0] shown_minute;
		logic       is_synced;
		logic       has_error;
		logic       in_startup;
		logic       minute_done;
	} dcf_out_t;

	// configuration register indexes
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ONE_MIN  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ONE_MAX  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAP_MIN  = 3'd4;

	// register reset values
	localparam logic [7:0] ZERO_MIN_RST = 8'd8;
	localparam logic [7:0] ZERO_MAX_RST = 8'd13;
	localparam logic [7:0] ONE_MIN_RST  = 8'd18;
	localparam logic [7:0] ONE_MAX_RST  = 8'd23;
	localparam logic [7:0] GAP_MIN_RST  = 8'd93;

	// frame positions (second index within the minute)
	localparam logic [5:0] SEC_START    = 6'd20;
	localparam logic [5:0] SEC_MIN_LSB  = 6'd21;
	localparam logic [5:0] SEC_MIN_B1   = 6'd22;
	localparam logic [5:0] SEC_MIN_B2   = 6'd23;
	localparam logic [5:0] SEC_MIN_B3   = 6'd24;
	localparam logic [5:0] SEC_MIN_T10  = 6'd25;
	localparam logic [5:0] SEC_MIN_T20  = 6'd26;
	localparam logic [5:0] SEC_MIN_T40  = 6'd27;
	localparam logic [5:0] SEC_MIN_PAR  = 6'd28;
	localparam logic [5:0] SEC_HR_LSB   = 6'd29;
	localparam logic [5:0] SEC_HR_B1    = 6'd30;
	localparam logic [5:0] SEC_HR_B2    = 6'd31;
	localparam logic [5:0] SEC_HR_B3    = 6'd32;
	localparam logic [5:0] SEC_HR_T10   = 6'd33;
	localparam logic [5:0] SEC_HR_T20   = 6'd34;
	localparam logic [5:0] SEC_HR_PAR   = 6'd35;
	localparam logic [5:0] SEC_SAT      = 6'd63;
	localparam logic [5:0] SEC_EARLY_LO = 6'd3;
	localparam logic [5:0] SEC_FRAME    = 6'd59;

	// time limits
	localparam logic [6:0] MIN_LIMIT = 7'd59;
	localparam logic [5:0] HR_LIMIT  = 6'd23;
	localparam logic [5:0] MIN_LAST  = 6'd59;
	localparam logic [5:0] HR_WRAP   = 6'd24;

endpackage

// ===== design/dcf77_time_code_decoder_core.sv =====
`timescale 1ns / 1ps

// DCF77 minute frame decoder.
// Input channel (in_valid / in_stall / in_data): one beat per received second,
// carrying the pulse length and the following gap length in ticks.
// Output channel (out_valid / out_stall / out_data): exactly one beat per input
// beat, carrying the displayed hour and minute, the sync, error and start-up
// flags and a marker for the beat that closed a minute frame.
// An accepted beat waits in the input register, then the decode and time update
// run in one pass into the output register. Throughput is one beat per cycle while
// the receiver does not stall; the decoder state is updated in the same cycle the
// beat moves to the output register.
// When the receiver stalls, the output register holds its beat and the input
// register holds the next one; in_stall rises only when both are full.
// Configuration (wr_en / wr_index / wr_data) sets the five tick windows; the user must
// write it only while the block is idle, not enforced here; unknown indexes are dropped.
// Reset clears both registers, restores the default windows, shows 0:00 and
// sets the start-up flag.
module dcf77_time_code_decoder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  dcf77_pkg::dcf_in_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output dcf77_pkg::dcf_out_t                  out_data,
	input  logic                                 wr_en,
	input  logic [dcf77_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [7:0]                           wr_data
);
	import dcf77_pkg::*;

	// configuration registers
	logic [7:0] zero_min_q, zero_max_q, one_min_q, one_max_q, gap_min_q;

	// input stage
	logic    valid_s1;
	dcf_in_t data_s1;

	// output stage
	logic     out_valid_q;
	dcf_out_t out_q;

	// decoder state
	logic [5:0] sec_q;
	logic [6:0] fmin_q;
	logic [5:0] fhr_q;
	logic       mpar_q, hpar_q, pend_q;
	logic       synced_q, error_q, startup_q;
	logic [4:0] dhr_q;
	logic [5:0] dmin_q;

	// next-state values
	logic       is_zero, is_one, bit_ok, b;
	logic [6:0] fmin_d;
	logic [5:0] fhr_d;
	logic       mpar_d, hpar_d, pend_d;
	logic [6:0] fmin_n;
	logic [5:0] fhr_n;
	logic       pend_n;
	logic [5:0] sec_inc;
	logic       mark, early, commit, range_bad, err_c;
	logic [5:0] sec_d;
	logic       synced_d, error_d, startup_d;
	logic [4:0] dhr_d;
	logic [5:0] dmin_d;
	logic [5:0] hr_adv;
	logic       advance;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q <= ZERO_MIN_RST;
			zero_max_q <= ZERO_MAX_RST;
			one_min_q  <= ONE_MIN_RST;
			one_max_q  <= ONE_MAX_RST;
			gap_min_q  <= GAP_MIN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ZERO_MIN: zero_min_q <= wr_data;
				REG_ZERO_MAX: zero_max_q <= wr_data;
				REG_ONE_MIN:  one_min_q  <= wr_data;
				REG_ONE_MAX:  one_max_q  <= wr_data;
				REG_GAP_MIN:  gap_min_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// pulse classification, zero window has priority
	always_comb begin
		is_zero = (data_s1.on_ticks >= zero_min_q) && (data_s1.on_ticks <= zero_max_q);
		is_one  = !is_zero && (data_s1.on_ticks >= one_min_q)
			&& (data_s1.on_ticks <= one_max_q);
		bit_ok  = is_zero || is_one;
		b       = is_one;
	end

	// bit decode into the frame registers
	always_comb begin
		fmin_d = fmin_q;
		fhr_d  = fhr_q;
		mpar_d = mpar_q;
		hpar_d = hpar_q;
		pend_d = pend_q;
		if (bit_ok) begin
			unique case (sec_q)
				SEC_START: if (!b) pend_d = 1'b1;
				SEC_MIN_LSB: begin
					fmin_d = {6'd0, b};
					mpar_d = b;
				end
				SEC_MIN_B1, SEC_MIN_B2, SEC_MIN_B3: begin
					fmin_d = fmin_q | ({6'd0, b} << (sec_q - SEC_MIN_LSB));
					mpar_d = mpar_q ^ b;
				end
				SEC_MIN_T10: begin
					fmin_d = b ? fmin_q + 7'd10 : fmin_q;
					mpar_d = mpar_q ^ b;
				end
				SEC_MIN_T20: begin
					fmin_d = b ? fmin_q + 7'd20 : fmin_q;
					mpar_d = mpar_q ^ b;
				end
				SEC_MIN_T40: begin
					fmin_d = b ? fmin_q + 7'd40 : fmin_q;
					mpar_d = mpar_q ^ b;
				end
				SEC_MIN_PAR: if (mpar_q ^ b) pend_d = 1'b1;
				SEC_HR_LSB: begin
					fhr_d  = {5'd0, b};
					hpar_d = b;
				end
				SEC_HR_B1, SEC_HR_B2, SEC_HR_B3: begin
					fhr_d  = fhr_q | ({5'd0, b} << (sec_q - SEC_HR_LSB));
					hpar_d = hpar_q ^ b;
				end
				SEC_HR_T10: begin
					fhr_d  = b ? fhr_q + 6'd10 : fhr_q;
					hpar_d = hpar_q ^ b;
				end
				SEC_HR_T20: begin
					fhr_d  = b ? fhr_q + 6'd20 : fhr_q;
					hpar_d = hpar_q ^ b;
				end
				SEC_HR_PAR: if (hpar_q ^ b) pend_d = 1'b1;
				default: ;
			endcase
		end else if (data_s1.on_ticks != 8'd0 && sec_q >= SEC_MIN_LSB
				&& sec_q <= SEC_HR_PAR) begin
			pend_d = 1'b1;
		end
	end

	// minute mark handling and display update
	always_comb begin
		sec_inc   = (sec_q == SEC_SAT) ? sec_q : sec_q + 6'd1;
		mark      = data_s1.off_ticks >= gap_min_q;
		early     = mark && (sec_inc >= SEC_EARLY_LO) && (sec_inc < SEC_FRAME);
		commit    = mark && (sec_inc >= SEC_FRAME);
		range_bad = (fhr_d > HR_LIMIT) || (fmin_d > MIN_LIMIT);
		err_c     = pend_d || range_bad;
		hr_adv    = {1'b0, dhr_q} + ((dmin_q >= MIN_LAST) ? 6'd1 : 6'd0);

		sec_d     = sec_inc;
		fmin_n    = fmin_d;
		fhr_n     = fhr_d;
		pend_n    = pend_d;
		synced_d  = synced_q;
		error_d   = error_q;
		startup_d = startup_q;
		dhr_d     = dhr_q;
		dmin_d    = dmin_q;

		priority if (early) begin
			synced_d  = 1'b1;
			startup_d = 1'b0;
			error_d   = 1'b0;
			pend_n    = 1'b0;
			sec_d     = 6'd0;
		end else if (commit) begin
			error_d = err_c;
			pend_n  = 1'b0;
			sec_d   = 6'd0;
			if (range_bad) begin
				fhr_n  = 6'd0;
				fmin_n = 7'd0;
			end
			if (!err_c) begin
				synced_d  = 1'b1;
				startup_d = 1'b0;
				dhr_d     = fhr_n[4:0];
				dmin_d    = fmin_n[5:0];
			end else begin
				synced_d = 1'b0;
				if (dhr_q == 5'd0 && dmin_q == 6'd0) begin
					dhr_d  = fhr_n[4:0];
					dmin_d = fmin_n[5:0];
				end else begin
					dmin_d = (dmin_q >= MIN_LAST) ? 6'd0 : dmin_q + 6'd1;
					dhr_d  = (hr_adv >= HR_WRAP) ? 5'd0 : hr_adv[4:0];
				end
			end
		end else begin
			sec_d = sec_inc;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// decoder state, updated as a beat moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q     <= 6'd0;
			fmin_q    <= 7'd0;
			fhr_q     <= 6'd0;
			mpar_q    <= 1'b0;
			hpar_q    <= 1'b0;
			pend_q    <= 1'b0;
			synced_q  <= 1'b0;
			error_q   <= 1'b0;
			startup_q <= 1'b1;
			dhr_q     <= 5'd0;
			dmin_q    <= 6'd0;
		end else if (advance) begin
			sec_q     <= sec_d;
			fmin_q    <= fmin_n;
			fhr_q     <= fhr_n;
			mpar_q    <= mpar_d;
			hpar_q    <= hpar_d;
			pend_q    <= pend_n;
			synced_q  <= synced_d;
			error_q   <= error_d;
			startup_q <= startup_d;
			dhr_q     <= dhr_d;
			dmin_q    <= dmin_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.shown_hour   <= dhr_d;
			out_q.shown_minute <= dmin_d;
			out_q.is_synced    <= synced_d;
			out_q.has_error    <= error_d;
			out_q.in_startup   <= startup_d;
			out_q.minute_done  <= commit;
		end
	end

`ifndef ASSERT_OFF
	// a closed frame restarts the second count
	a_commit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (early || commit) |=> sec_q == 6'd0)
		else $error("second index not restarted after minute mark");

	// a closed frame is either synced or in error, never both
	a_done_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.minute_done |-> out_q.is_synced != out_q.has_error)
		else $error("sync and error flags disagree on closed frame");

	// displayed time stays a legal clock time
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.shown_hour <= 5'd23) && (out_q.shown_minute <= 6'd59))
		else $error("displayed time out of range");
`endif

endmodule

// ===== tb/dcf77_display_checker.sv =====
`timescale 1ns / 1ps

module dcf77_display_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  dcf77_pkg::dcf_in_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  dcf77_pkg::dcf_out_t             out_data,
	input  logic                            wr_en,
	input  logic [dcf77_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [7:0]                      wr_data,
	output int                              fail_count,
	output int                              outstanding,
	output int                              minutes_closed
);
	import dcf77_pkg::*;

	// tick windows as last written
	logic [7:0] zero_lo, zero_hi, one_lo, one_hi, mark_gap;

	// decoder state as the block should hold it
	logic [5:0] sec_count;
	logic [6:0] rx_minutes;
	logic [5:0] rx_hours;
	logic       min_par, hr_par, err_pending;
	logic       synced, err, startup;
	logic [4:0] disp_hr;
	logic [5:0] disp_min;

	// displayed time and flags still to come out, oldest first
	dcf_out_t display_q [$];
	dcf_out_t want, seen, next_shown;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (fail_count < 40)
			$display("mismatch at %0t ns: %s got %0d, want %0d", $time, what, got, exp_val);
		fail_count++;
	endtask

	// one classified bit at the current frame position
	task automatic decode_bit(input logic b);
		case (sec_count)
			SEC_START: begin
				if (!b)
					err_pending = 1'b1;
			end
			SEC_MIN_LSB: begin
				rx_minutes = {6'd0, b};
				min_par = b;
			end
			SEC_MIN_B1, SEC_MIN_B2, SEC_MIN_B3: begin
				rx_minutes[sec_count - SEC_MIN_LSB] |= b;
				min_par ^= b;
			end
			SEC_MIN_T10: begin
				rx_minutes = rx_minutes + (b ? 7'd10 : 7'd0);
				min_par ^= b;
			end
			SEC_MIN_T20: begin
				rx_minutes = rx_minutes + (b ? 7'd20 : 7'd0);
				min_par ^= b;
			end
			SEC_MIN_T40: begin
				rx_minutes = rx_minutes + (b ? 7'd40 : 7'd0);
				min_par ^= b;
			end
			SEC_MIN_PAR: begin
				if (min_par ^ b)
					err_pending = 1'b1;
			end
			SEC_HR_LSB: begin
				rx_hours = {5'd0, b};
				hr_par = b;
			end
			SEC_HR_B1, SEC_HR_B2, SEC_HR_B3: begin
				rx_hours[sec_count - SEC_HR_LSB] |= b;
				hr_par ^= b;
			end
			SEC_HR_T10: begin
				rx_hours = rx_hours + (b ? 6'd10 : 6'd0);
				hr_par ^= b;
			end
			SEC_HR_T20: begin
				rx_hours = rx_hours + (b ? 6'd20 : 6'd0);
				hr_par ^= b;
			end
			SEC_HR_PAR: begin
				if (hr_par ^ b)
					err_pending = 1'b1;
			end
			default: ;
		endcase
	endtask

	// advance the decoder by one measured second and give the shown result
	task automatic predict_display(input dcf_in_t beat, output dcf_out_t shown);
		logic done;
		done = 1'b0;

		// pulse classification, zero window first
		if (beat.on_ticks >= zero_lo && beat.on_ticks <= zero_hi)
			decode_bit(1'b0);
		else if (beat.on_ticks >= one_lo && beat.on_ticks <= one_hi)
			decode_bit(1'b1);
		else if (beat.on_ticks != 8'd0 && sec_count > SEC_START && sec_count <= SEC_HR_PAR)
			err_pending = 1'b1;

		if (sec_count < SEC_SAT)
			sec_count = sec_count + 6'd1;

		// minute mark: early resync or commit of the frame
		if (beat.off_ticks >= mark_gap && sec_count < SEC_FRAME && sec_count >= SEC_EARLY_LO) begin
			synced = 1'b1;
			startup = 1'b0;
			err = 1'b0;
			err_pending = 1'b0;
			sec_count = '0;
		end else if (beat.off_ticks >= mark_gap && sec_count >= SEC_FRAME) begin
			done = 1'b1;
			err = err_pending;
			err_pending = 1'b0;
			sec_count = '0;
			synced = 1'b1;
			if (rx_hours > HR_LIMIT || rx_minutes > MIN_LIMIT) begin
				err = 1'b1;
				rx_hours = '0;
				rx_minutes = '0;
			end
			if (!err) begin
				disp_hr = rx_hours[4:0];
				disp_min = rx_minutes[5:0];
				startup = 1'b0;
			end else begin
				synced = 1'b0;
				if (disp_hr == 5'd0 && disp_min == 6'd0) begin
					disp_hr = rx_hours[4:0];
					disp_min = rx_minutes[5:0];
				end else begin
					disp_min = disp_min + 6'd1;
					if (disp_min > MIN_LAST) begin
						disp_min = '0;
						disp_hr = disp_hr + 5'd1;
					end
					if (disp_hr >= HR_WRAP)
						disp_hr = '0;
				end
			end
		end

		shown = '{shown_hour: disp_hr, shown_minute: disp_min, is_synced: synced,
			has_error: err, in_startup: startup, minute_done: done};
	endtask

	// watch both channels and the write port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_lo = ZERO_MIN_RST;
			zero_hi = ZERO_MAX_RST;
			one_lo = ONE_MIN_RST;
			one_hi = ONE_MAX_RST;
			mark_gap = GAP_MIN_RST;
			sec_count = '0;
			rx_minutes = '0;
			rx_hours = '0;
			min_par = 1'b0;
			hr_par = 1'b0;
			err_pending = 1'b0;
			synced = 1'b0;
			err = 1'b0;
			startup = 1'b1;
			disp_hr = '0;
			disp_min = '0;
			display_q.delete();
			fail_count = 0;
			minutes_closed = 0;
			outstanding <= 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				seen = out_data;
				if (display_q.size() == 0) begin
					report_mismatch("result beat with nothing expected, minute",
						seen.shown_minute, -1);
				end else begin
					want = display_q.pop_front();
					if (seen.shown_hour !== want.shown_hour)
						report_mismatch("shown_hour", seen.shown_hour, want.shown_hour);
					if (seen.shown_minute !== want.shown_minute)
						report_mismatch("shown_minute", seen.shown_minute, want.shown_minute);
					if (seen.is_synced !== want.is_synced)
						report_mismatch("is_synced", seen.is_synced, want.is_synced);
					if (seen.has_error !== want.has_error)
						report_mismatch("has_error", seen.has_error, want.has_error);
					if (seen.in_startup !== want.in_startup)
						report_mismatch("in_startup", seen.in_startup, want.in_startup);
					if (seen.minute_done !== want.minute_done)
						report_mismatch("minute_done", seen.minute_done, want.minute_done);
					if (want.minute_done)
						minutes_closed++;
				end
			end

			// register writes
			if (wr_en) begin
				case (wr_index)
					REG_ZERO_MIN: zero_lo = wr_data;
					REG_ZERO_MAX: zero_hi = wr_data;
					REG_ONE_MIN:  one_lo = wr_data;
					REG_ONE_MAX:  one_hi = wr_data;
					REG_GAP_MIN:  mark_gap = wr_data;
					default: ;
				endcase
			end

			// accepted input beat
			if (in_valid && !in_stall) begin
				predict_display(in_data, next_shown);
				display_q.push_back(next_shown);
			end

			outstanding <= display_q.size();
		end
	end

endmodule

// ===== tb/tb_dcf77_time_code_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_dcf77_time_code_decoder_core;
	import dcf77_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [3:0] {
		FAULT_NONE,
		FAULT_START_BIT,
		FAULT_MIN_PARITY,
		FAULT_HR_PARITY,
		FAULT_BAD_PULSE,
		FAULT_NO_PULSE,
		FAULT_RANGE,
		FAULT_EARLY_MARK,
		FAULT_LATE_MARK
	} frame_fault_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	dcf_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	dcf_out_t             out_data;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = REG_ZERO_MIN;
	logic [7:0]           wr_data = '0;

	// windows as the generator currently believes them
	logic [7:0] windows [0:4];
	logic       steady = 1'b0;
	int         items_sent = 0;
	int         frames_sent = 0;
	int         cycle_count = 0;
	int         fail_count, outstanding, minutes_closed;

	dcf77_time_code_decoder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	dcf77_display_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.minutes_closed (minutes_closed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, off during the steady phase
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99, 0) < 17);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic in_zero_window(input logic [7:0] v);
		return v >= windows[REG_ZERO_MIN] && v <= windows[REG_ZERO_MAX];
	endfunction

	// gap lengths either side of the minute mark threshold
	function automatic logic [7:0] short_gap();
		if (windows[REG_GAP_MIN] == 8'd0)
			return 8'($urandom);
		return 8'($urandom_range(windows[REG_GAP_MIN] - 8'd1, 0));
	endfunction

	function automatic logic [7:0] mark_gap();
		return 8'($urandom_range(255, windows[REG_GAP_MIN]));
	endfunction

	// pulse length that reads as the wanted bit where the windows allow it
	function automatic logic [7:0] pulse_for(input logic one_bit);
		logic [7:0] v;
		int tries;
		if (!one_bit) begin
			if (windows[REG_ZERO_MIN] <= windows[REG_ZERO_MAX])
				return 8'($urandom_range(windows[REG_ZERO_MAX], windows[REG_ZERO_MIN]));
			return 8'($urandom);
		end
		v = 8'($urandom);
		for (tries = 0; tries < 8; tries++) begin
			if (windows[REG_ONE_MIN] <= windows[REG_ONE_MAX])
				v = 8'($urandom_range(windows[REG_ONE_MAX], windows[REG_ONE_MIN]));
			if (!in_zero_window(v))
				break;
		end
		return v;
	endfunction

	// nonzero pulse outside both windows, or no pulse if none is found
	function automatic logic [7:0] bad_pulse();
		logic [7:0] v;
		int tries;
		for (tries = 0; tries < 16; tries++) begin
			v = 8'($urandom_range(255, 1));
			if (!in_zero_window(v) && !(v >= windows[REG_ONE_MIN] && v <= windows[REG_ONE_MAX]))
				return v;
		end
		return 8'd0;
	endfunction

	// one input beat, with an occasional idle gap ahead of it
	task automatic send_second(input logic [7:0] on_len, input logic [7:0] off_len);
		if (!steady && $urandom_range(99, 0) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{on_ticks: on_len, off_ticks: off_len};
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// a minute frame with random content and at most one fault
	task automatic send_frame(input frame_fault_e fault);
		logic [95:0] bits;
		logic [3:0]  min_units, hr_units;
		logic [2:0]  min_tens;
		logic [1:0]  hr_tens;
		logic [7:0]  on_len, off_len;
		int          last, odd_sec, s, value;
		bits = {$urandom, $urandom, $urandom};
		if (fault == FAULT_RANGE) begin
			min_units = 4'($urandom);
			min_tens = 3'($urandom);
			hr_units = 4'($urandom);
			hr_tens = 2'($urandom);
		end else begin
			value = $urandom_range(59, 0);
			min_units = 4'(value % 10);
			min_tens = 3'(value / 10);
			value = $urandom_range(23, 0);
			hr_units = 4'(value % 10);
			hr_tens = 2'(value / 10);
		end
		bits[SEC_START] = 1'b1;
		bits[SEC_MIN_B3:SEC_MIN_LSB] = min_units;
		bits[SEC_MIN_T40:SEC_MIN_T10] = min_tens;
		bits[SEC_MIN_PAR] = ^{min_tens, min_units};
		bits[SEC_HR_B3:SEC_HR_LSB] = hr_units;
		bits[SEC_HR_T20:SEC_HR_T10] = hr_tens;
		bits[SEC_HR_PAR] = ^{hr_tens, hr_units};

		last = SEC_FRAME - 1;
		odd_sec = $urandom_range(SEC_HR_PAR, SEC_MIN_LSB);
		case (fault)
			FAULT_START_BIT:  bits[SEC_START] = 1'b0;
			FAULT_MIN_PARITY: bits[SEC_MIN_PAR] = ~bits[SEC_MIN_PAR];
			FAULT_HR_PARITY:  bits[SEC_HR_PAR] = ~bits[SEC_HR_PAR];
			FAULT_EARLY_MARK: last = $urandom_range(SEC_FRAME - 2, 1);
			FAULT_LATE_MARK:  last = SEC_FRAME - 1 + $urandom_range(10, 1);
			default: ;
		endcase

		for (s = 0; s <= last; s++) begin
			on_len = pulse_for(bits[s]);
			if (s == odd_sec && fault == FAULT_BAD_PULSE)
				on_len = bad_pulse();
			if (s == odd_sec && fault == FAULT_NO_PULSE)
				on_len = 8'd0;
			off_len = (s == last) ? mark_gap() : short_gap();
			send_second(on_len, off_len);
		end
		frames_sent++;
	endtask

	// mostly frames, some bursts of raw noise
	task automatic run_random(input int budget);
		int stop_at, burst, k;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if ($urandom_range(99, 0) < 75) begin
				k = $urandom_range(19, 0);
				send_frame(k < 8 ? frame_fault_e'(k + 1) : FAULT_NONE);
			end else begin
				burst = $urandom_range(20, 1);
				repeat (burst)
					send_second(8'($urandom), ($urandom_range(9, 0) == 0) ? mark_gap() : 8'($urandom));
			end
		end
	endtask

	// stop sending and wait for every result to come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		windows[idx] = v;
		@(posedge clk);
	endtask

	task automatic apply_windows(input logic [7:0] z_lo, z_hi, o_lo, o_hi, gap);
		write_reg(REG_ZERO_MIN, z_lo);
		write_reg(REG_ZERO_MAX, z_hi);
		write_reg(REG_ONE_MIN, o_lo);
		write_reg(REG_ONE_MAX, o_hi);
		write_reg(REG_GAP_MIN, gap);
		wr_en <= 1'b0;
	endtask

	initial begin
		windows[REG_ZERO_MIN] = ZERO_MIN_RST;
		windows[REG_ZERO_MAX] = ZERO_MAX_RST;
		windows[REG_ONE_MIN] = ONE_MIN_RST;
		windows[REG_ONE_MAX] = ONE_MAX_RST;
		windows[REG_GAP_MIN] = GAP_MIN_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// marks at counts one and two are ignored, then an early resync
		send_second(8'd0, 8'd255);
		send_second(8'd255, 8'd255);
		send_second(ZERO_MIN_RST, GAP_MIN_RST - 8'd1);
		send_second(ZERO_MAX_RST, GAP_MIN_RST);
		// pulse lengths either side of each window edge
		send_second(ZERO_MIN_RST - 8'd1, 8'd0);
		send_second(ZERO_MAX_RST + 8'd1, 8'd0);
		send_second(ONE_MIN_RST - 8'd1, 8'd0);
		send_second(ONE_MIN_RST, 8'd0);
		send_second(ONE_MAX_RST, 8'd0);
		send_second(ONE_MAX_RST + 8'd1, 8'd0);
		send_second(8'h55, 8'haa);
		send_second(8'haa, 8'h55);

		// reset windows
		run_random(340);
		drain();

		// narrow zero window, wide one window, short mark, no idling at all
		steady <= 1'b1;
		apply_windows(8'd5, 8'd9, 8'd15, 8'd25, 8'd60);
		run_random(130);
		drain();
		steady <= 1'b0;

		// a missing pulse reads as zero, every other pulse as one, mark only at full gap
		apply_windows(8'd0, 8'd0, 8'd1, 8'd255, 8'd255);
		run_random(130);
		drain();

		// overlapping windows and every gap a mark
		apply_windows(8'd10, 8'd20, 8'd15, 8'd30, 8'd0);
		run_random(100);
		drain();

		// empty zero window, one window a single value
		apply_windows(8'd200, 8'd100, 8'd255, 8'd255, 8'd1);
		run_random(100);
		drain();

		// back to the usual windows
		apply_windows(ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, GAP_MIN_RST);
		run_random(180);
		drain();
		repeat (6) @(posedge clk);

		$display("sent %0d seconds, including %0d generated minute frames, over six window settings",
			items_sent, frames_sent);
		$display("decoder closed %0d minute frames under random idling and back-pressure",
			minutes_closed);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
